// ===== hdl/bsc_pkg.sv =====
package bsc_pkg;

    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SENS_C1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TC_C3  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TC_C4   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TREF_C5     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TSLOPE_C6   = 3'd5;

    localparam logic signed [19:0] TEMP_MID = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW = -20'sd1500;
    localparam logic [16:0] PRESSURE_MAX = 17'd131071;

    typedef struct packed {
        logic [23:0] pressure_raw;
        logic [23:0] temperature_raw;
    } bsc_in_t;

    typedef struct packed {
        logic signed [18:0] temperature_centi;
        logic [16:0]        pressure_pa;
        logic               pressure_clipped;
    } bsc_out_t;

endpackage

// ===== hdl/baro_sensor_compensation.sv =====
// Second-order barometric compensation: each item carries raw pressure and
// temperature conversions and yields temperature in 0.01 degC and pressure in
// Pa, saturated to 0..131071 with a clip flag. The datapath is a nine-stage
// pipeline that takes one item every cycle unless a stall holds it; the
// stage count is set by the chain of multipliers (temperature products, the
// low-temperature squares, and the final 24 by 41 bit pressure product, which
// is split into two partial products). Each stage holds its item on a stall
// and empty stages fill up, so s_ready falls only when all nine stages are
// full and m_ready is low. Calibration words are written through the cfg port
// and must only change while the pipeline is empty.
module baro_sensor_compensation (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [15:0]              cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  bsc_pkg::bsc_in_t         s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bsc_pkg::bsc_out_t        m_data
);
    import bsc_pkg::*;

    localparam int NSTG = 9;

    logic [CFG_DATA_W-1:0] coef_reg [NUM_REGS];
    logic [NSTG-1:0] valid_reg, valid_next, adv;

    // stage 0
    logic signed [24:0] dt_s0_reg, dt_next;
    logic [23:0] d1_s0_reg, d1_s1_reg, d1_s2_reg, d1_s3_reg, d1_s4_reg, d1_s5_reg;
    // stage 1
    logic signed [41:0] dtc6_s1_reg, dtc6_next, dtc4_s1_reg, dtc4_next, dtc3_s1_reg, dtc3_next;
    logic signed [49:0] dtsq_s1_reg, dtsq_next;
    // stage 2
    logic signed [19:0] temp_s2_reg, temp_next;
    logic signed [35:0] off_s2_reg, off_next, off_s3_reg, off_s4_reg;
    logic signed [34:0] sens_s2_reg, sens_next, sens_s3_reg, sens_s4_reg;
    logic [17:0] t2_s2_reg, t2_next;
    // stage 3
    logic [34:0] losq_s3_reg, losq_next, vlosq_s3_reg, vlosq_next;
    logic lt_mid_s3_reg, lt_mid_next, lt_low_s3_reg, lt_low_next;
    logic signed [19:0] tout_s3_reg, tout_next, tout_s4_reg, tout_s5_reg, tout_s6_reg;
    logic signed [19:0] tout_s7_reg;
    logic signed [20:0] lo, vlo;
    logic signed [41:0] lo_prod, vlo_prod;
    // stage 4
    logic [38:0] off2_s4_reg, off2_next, sens2_s4_reg, sens2_next;
    logic [38:0] lo5, v7, v11;
    // stage 5
    logic signed [40:0] offc_s5_reg, offc_next, offc_s6_reg, offc_s7_reg;
    logic signed [40:0] sensc_s5_reg, sensc_next;
    // stage 6
    logic [43:0] pplo_s6_reg, pplo_next;
    logic signed [45:0] pphi_s6_reg, pphi_next;
    // stage 7
    logic signed [65:0] prod_s7_reg, prod_next;
    // stage 8
    logic signed [45:0] diff;
    logic neg, over;
    bsc_out_t out_s8_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    // per-stage advance so bubbles collapse under a stall
    always_comb begin
        adv[NSTG-1] = ~valid_reg[NSTG-1] | m_ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            adv[k] = ~valid_reg[k] | adv[k+1];
        end
        valid_next[0] = adv[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NSTG-1];
    assign m_data  = out_s8_reg;

    always_comb begin
        dt_next = $signed({1'b0, s_data.temperature_raw})
                - $signed({1'b0, coef_reg[REG_TREF_C5], 8'd0});

        dtc6_next = dt_s0_reg * $signed({1'b0, coef_reg[REG_TSLOPE_C6]});
        dtc4_next = dt_s0_reg * $signed({1'b0, coef_reg[REG_OFF_TC_C4]});
        dtc3_next = dt_s0_reg * $signed({1'b0, coef_reg[REG_SENS_TC_C3]});
        dtsq_next = dt_s0_reg * dt_s0_reg;

        temp_next = 20'(dtc6_s1_reg >>> 23) + TEMP_MID;
        off_next  = $signed({4'b0, coef_reg[REG_OFFSET_C2], 16'd0}) + 36'(dtc4_s1_reg >>> 7);
        sens_next = $signed({4'b0, coef_reg[REG_SENS_C1], 15'd0}) + 35'(dtc3_s1_reg >>> 8);
        t2_next   = dtsq_s1_reg[48:31];

        lo          = 21'(temp_s2_reg) - 21'(TEMP_MID);
        vlo         = 21'(temp_s2_reg) - 21'(TEMP_LOW);
        lo_prod     = lo * lo;
        vlo_prod    = vlo * vlo;
        losq_next   = lo_prod[34:0];
        vlosq_next  = vlo_prod[34:0];
        lt_mid_next = temp_s2_reg < TEMP_MID;
        lt_low_next = temp_s2_reg < TEMP_LOW;
        // second-order term only applies below the mid threshold
        tout_next   = lt_mid_next ? temp_s2_reg - $signed({2'b0, t2_s2_reg}) : temp_s2_reg;

        lo5 = {4'b0, losq_s3_reg} + {2'b0, losq_s3_reg, 2'b0};
        v7  = {1'b0, vlosq_s3_reg, 3'b0} - {4'b0, vlosq_s3_reg};
        v11 = {1'b0, vlosq_s3_reg, 3'b0} + {3'b0, vlosq_s3_reg, 1'b0} + {4'b0, vlosq_s3_reg};
        off2_next  = (lt_mid_s3_reg ? (lo5 >> 1) : '0) + (lt_low_s3_reg ? v7 : '0);
        sens2_next = (lt_mid_s3_reg ? (lo5 >> 2) : '0) + (lt_low_s3_reg ? (v11 >> 1) : '0);

        offc_next  = 41'(off_s4_reg) - $signed({2'b0, off2_s4_reg});
        sensc_next = 41'(sens_s4_reg) - $signed({2'b0, sens2_s4_reg});

        pplo_next = d1_s5_reg * sensc_s5_reg[19:0];
        pphi_next = $signed({1'b0, d1_s5_reg}) * $signed(sensc_s5_reg[40:20]);

        prod_next = (66'(pphi_s6_reg) <<< 20) + $signed({22'b0, pplo_s6_reg});

        diff = 46'(prod_s7_reg >>> 21) - 46'(offc_s7_reg);
        neg  = diff[45];
        over = !neg && (|diff[44:32]);
        out_next.temperature_centi = tout_s7_reg[18:0];
        out_next.pressure_pa       = neg ? '0 : (over ? PRESSURE_MAX : diff[31:15]);
        out_next.pressure_clipped  = neg | over;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            dt_s0_reg <= dt_next;
            d1_s0_reg <= s_data.pressure_raw;
        end
        if (adv[1]) begin
            dtc6_s1_reg <= dtc6_next;
            dtc4_s1_reg <= dtc4_next;
            dtc3_s1_reg <= dtc3_next;
            dtsq_s1_reg <= dtsq_next;
            d1_s1_reg   <= d1_s0_reg;
        end
        if (adv[2]) begin
            temp_s2_reg <= temp_next;
            off_s2_reg  <= off_next;
            sens_s2_reg <= sens_next;
            t2_s2_reg   <= t2_next;
            d1_s2_reg   <= d1_s1_reg;
        end
        if (adv[3]) begin
            losq_s3_reg   <= losq_next;
            vlosq_s3_reg  <= vlosq_next;
            lt_mid_s3_reg <= lt_mid_next;
            lt_low_s3_reg <= lt_low_next;
            tout_s3_reg   <= tout_next;
            off_s3_reg    <= off_s2_reg;
            sens_s3_reg   <= sens_s2_reg;
            d1_s3_reg     <= d1_s2_reg;
        end
        if (adv[4]) begin
            off2_s4_reg  <= off2_next;
            sens2_s4_reg <= sens2_next;
            off_s4_reg   <= off_s3_reg;
            sens_s4_reg  <= sens_s3_reg;
            tout_s4_reg  <= tout_s3_reg;
            d1_s4_reg    <= d1_s3_reg;
        end
        if (adv[5]) begin
            offc_s5_reg  <= offc_next;
            sensc_s5_reg <= sensc_next;
            tout_s5_reg  <= tout_s4_reg;
            d1_s5_reg    <= d1_s4_reg;
        end
        if (adv[6]) begin
            pplo_s6_reg <= pplo_next;
            pphi_s6_reg <= pphi_next;
            offc_s6_reg <= offc_s5_reg;
            tout_s6_reg <= tout_s5_reg;
        end
        if (adv[7]) begin
            prod_s7_reg <= prod_next;
            offc_s7_reg <= offc_s6_reg;
            tout_s7_reg <= tout_s6_reg;
        end
        if (adv[8]) begin
            out_s8_reg <= out_next;
        end
    end

endmodule

// ===== hdl/bsc_checker.sv =====
module bsc_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input bsc_pkg::bsc_out_t        m_data
);
    import bsc_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // flag clear whenever pressure lies strictly inside the range
    a_clip_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pressure_pa != 17'd0 && m_data.pressure_pa != PRESSURE_MAX
        |-> !m_data.pressure_clipped)
        else $error("clip flag set inside range");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.temperature_centi) >= -260139)
                 && ($signed(m_data.temperature_centi) <= 133071))
        else $error("temperature out of range");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

// ===== verif/tb_baro_sensor_compensation.sv =====
`timescale 1ns / 1ps

module tb_baro_sensor_compensation;
    import bsc_pkg::*;

    localparam int PIPE_LAT = 9;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAW_MAX = 16777215;
    localparam int TYPICAL_D1 = 9085466;
    localparam int TYPICAL_D2 = 8569150;
    localparam int RAND_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PAUSE_PHASE = 5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [CFG_DATA_W-1:0] TYPICAL_CAL [NUM_REGS] =
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    localparam int SEND_IDLE [4] = '{0, 72, 0, 17};
    localparam int RECV_STALL [4] = '{0, 0, 72, 17};

    typedef enum int {CAL_TYPICAL, CAL_ZERO, CAL_FULL, CAL_RANDOM, CAL_MIXED} cal_set_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    bsc_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    bsc_out_t              m_data;

    logic [CFG_DATA_W-1:0] cal_word [NUM_REGS] = '{default: '0};
    bsc_in_t               pending_q[$];
    bsc_out_t              expected_q[$];
    bsc_out_t              reading_want;
    logic                  s_fire = 1'b0;
    logic                  hold_send = 1'b0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    err_count = 0;
    int                    quiet_cycles = 0;

    baro_sensor_compensation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic bsc_out_t compensate(bsc_in_t item);
        longint d1, d2, dt, t, off, sens, t2, off2, sens2, lo, vlo, p;
        bsc_out_t res;
        d1 = longint'(item.pressure_raw);
        d2 = longint'(item.temperature_raw);
        dt = d2 - longint'(cal_word[REG_TREF_C5]) * 256;
        t = TEMP_MID + ((dt * longint'(cal_word[REG_TSLOPE_C6])) >>> 23);
        off = longint'(cal_word[REG_OFFSET_C2]) * 65536
            + ((longint'(cal_word[REG_OFF_TC_C4]) * dt) >>> 7);
        sens = longint'(cal_word[REG_SENS_C1]) * 32768
             + ((longint'(cal_word[REG_SENS_TC_C3]) * dt) >>> 8);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (t < TEMP_MID) begin
            lo = t - TEMP_MID;
            t2 = (dt * dt) >>> 31;
            off2 = (5 * lo * lo) >>> 1;
            sens2 = (5 * lo * lo) >>> 2;
            if (t < TEMP_LOW) begin
                vlo = t - TEMP_LOW;
                off2 = off2 + 7 * vlo * vlo;
                sens2 = sens2 + ((11 * vlo * vlo) >>> 1);
            end
        end
        t = t - t2;
        off = off - off2;
        sens = sens - sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        res.pressure_clipped = 1'b0;
        if (p < 0) begin
            p = 0;
            res.pressure_clipped = 1'b1;
        end else if (p > longint'(PRESSURE_MAX)) begin
            p = longint'(PRESSURE_MAX);
            res.pressure_clipped = 1'b1;
        end
        res.temperature_centi = t[18:0];
        res.pressure_pa = p[16:0];
        return res;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_fire) begin
                if (pending_q.size() != 0 && !hold_send
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data <= pending_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected item: temp %0d pressure %0d clip %0b", $time,
                             m_data.temperature_centi, m_data.pressure_pa,
                             m_data.pressure_clipped);
                    err_count++;
                end else begin
                    reading_want = expected_q.pop_front();
                    if (m_data !== reading_want) begin
                        $display("%0t: mismatch: expected temp %0d pressure %0d clip %0b, %s",
                                 $time, reading_want.temperature_centi,
                                 reading_want.pressure_pa, reading_want.pressure_clipped,
                                 $sformatf("got temp %0d pressure %0d clip %0b",
                                           m_data.temperature_centi, m_data.pressure_pa,
                                           m_data.pressure_clipped));
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(compensate(s_data));
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[baro_sensor_compensation] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx < NUM_REGS)
            cal_word[idx] = val;
    endtask

    task automatic load_calibration(input cal_set_t kind);
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (kind)
                CAL_TYPICAL: word = TYPICAL_CAL[i];
                CAL_ZERO:    word = '0;
                CAL_FULL:    word = '1;
                CAL_MIXED: begin
                    case ($urandom_range(0, 2))
                        0:       word = '0;
                        1:       word = '1;
                        default: word = CFG_DATA_W'($urandom_range(0, 65535));
                    endcase
                end
                default:     word = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_IDX_W'(i), word);
        end
        // out-of-range indexes must not disturb anything
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    endtask

    task automatic queue_reading(input longint d1, input longint d2);
        bsc_in_t item;
        item.pressure_raw = d1[23:0];
        item.temperature_raw = d2[23:0];
        pending_q.push_back(item);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    initial begin
        longint ref_d2, slope, cold, base, d1, d2;
        cal_set_t kind;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // calibration still at reset values
        queue_reading(0, 0);
        queue_reading(RAW_MAX, RAW_MAX);
        queue_reading(TYPICAL_D1, TYPICAL_D2);
        drain();

        load_calibration(CAL_TYPICAL);
        @(posedge aclk);
        ref_d2 = longint'(cal_word[REG_TREF_C5]) * 256;
        slope = longint'(cal_word[REG_TSLOPE_C6]);
        queue_reading(TYPICAL_D1, TYPICAL_D2);
        queue_reading(0, TYPICAL_D2);
        queue_reading(RAW_MAX, TYPICAL_D2);
        queue_reading(TYPICAL_D1, ref_d2);
        queue_reading(TYPICAL_D1, ref_d2 - 1);
        // land just below the lower threshold, then one step further below it
        cold = ((longint'(TEMP_MID - TEMP_LOW) << 23) + slope - 1) / slope;
        queue_reading(TYPICAL_D1, ref_d2 - cold);
        cold = ((longint'(TEMP_MID - TEMP_LOW + 1) << 23) + slope - 1) / slope;
        queue_reading(TYPICAL_D1, ref_d2 - cold);
        queue_reading(TYPICAL_D1, 0);
        queue_reading(TYPICAL_D1, RAW_MAX);
        queue_reading(0, 0);
        queue_reading(RAW_MAX, RAW_MAX);
        queue_reading(0, RAW_MAX);
        queue_reading(RAW_MAX, 0);
        drain();

        load_calibration(CAL_FULL);
        @(posedge aclk);
        queue_reading(0, 0);
        queue_reading(RAW_MAX, RAW_MAX);
        queue_reading(RAW_MAX, 0);
        queue_reading(0, RAW_MAX);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            case (ph)
                0:       kind = CAL_TYPICAL;
                1:       kind = CAL_FULL;
                2:       kind = CAL_ZERO;
                default: kind = (ph % 2) ? CAL_MIXED : CAL_RANDOM;
            endcase
            load_calibration(kind);
            @(posedge aclk);
            send_idle_pct = SEND_IDLE[ph % 4];
            recv_stall_pct = RECV_STALL[ph % 4];
            base = longint'(cal_word[REG_TREF_C5]) * 256;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // mostly temperatures around the reference, so cold corrections get hit
                if ($urandom_range(0, 99) < 20)
                    d2 = $urandom_range(0, RAW_MAX);
                else
                    d2 = base + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                if (d2 < 0)
                    d2 = 0;
                else if (d2 > RAW_MAX)
                    d2 = RAW_MAX;
                case ($urandom_range(0, 19))
                    0:       d1 = 0;
                    1:       d1 = RAW_MAX;
                    2, 3, 4, 5, 6, 7, 8, 9:
                             d1 = $urandom_range(TYPICAL_D1 - (1 << 20),
                                                 TYPICAL_D1 + (1 << 20));
                    default: d1 = $urandom_range(0, RAW_MAX);
                endcase
                queue_reading(d1, d2);
            end
            if (ph == PAUSE_PHASE) begin
                while (pending_q.size() > ITEMS_PER_PHASE / 2)
                    @(posedge aclk);
                hold_send = 1'b1;
                while (s_valid || expected_q.size() != 0)
                    @(posedge aclk);
                hold_send = 1'b0;
            end
        end
        drain();

        if (err_count == 0)
            $display("[baro_sensor_compensation] OK");
        else
            $display("[baro_sensor_compensation] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bsc_pkg.sv
hdl/baro_sensor_compensation.sv
hdl/bsc_checker.sv
verif/tb_baro_sensor_compensation.sv
